/* rtl/ufre_pkg.sv */
// Shared constants and types for the union-find redundant edge engine.
package ufre_pkg;

   localparam int NODES    = 1024;
   localparam int NODE_W   = 10;
   localparam int RANK_W   = 4;
   localparam int ENTRY_W  = RANK_W + NODE_W;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 8;

   localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
   localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);
   localparam logic [NODE_W-1:0] COUNT_RESET = NODE_W'(1023);

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } entry_type;

endpackage

/* rtl/ufre_ram.sv */
// Generic simple dual-port RAM with registered read and write-first forwarding.
module ufre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/union_find_redundant_edge.sv */
// Top level of the union-find engine that flags redundant, cycle-closing edges.
//
// Each request on the req_ channel carries one undirected edge (node_a, node_b)
// and a first-edge mark in req_tuser. The block finds the root of each endpoint
// in a single parent/rank memory, compresses both paths and merges the sets by
// rank. Every request yields exactly one response on the rsp_ channel with the
// redundant and bad_node flags.
// The find and compression walks grow with d_a + d_b, and equal ranks add
// a bump step that raises the surviving root's rank. d_a and d_b are the path
// lengths from the endpoints to their roots, at most log2 of the node count
// under union by rank. A bad endpoint skips the walks and goes from ST_START
// straight to ST_DONE. The memory takes one read and one write per cycle.
// A request with the first-edge mark first sweeps all 1024 memory entries.
// Requests are taken one at a time; the next is accepted while a finished
// response still waits in the output register.
// After reset the block sweeps all memory entries with req_tready low;
// csr_ writes to node_count are taken at any time.
// When the receiver stalls, the response is held and a following request
// finishes its work and then waits for the output register to free up.
module union_find_redundant_edge
   import ufre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // node_a [9:0], node_b [19:10], zero [23:20]
   input  logic              req_tuser,   // first_edge [0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // redundant [0], bad_node [1], zero [7:2]
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_FIND  = 3'd3;
   localparam logic [2:0] ST_COMP  = 3'd4;
   localparam logic [2:0] ST_MERGE = 3'd5;
   localparam logic [2:0] ST_BUMP  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic              pend_ff, pend_in;
   logic [NODE_W-1:0] clr_idx_ff, clr_idx_in;
   logic [NODE_W-1:0] node_count_ff;
   logic [NODE_W-1:0] node_a_ff, node_a_in;
   logic [NODE_W-1:0] node_b_ff, node_b_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic              sel_ff, sel_in;
   logic [NODE_W-1:0] root_a_ff, root_a_in;
   logic [NODE_W-1:0] root_b_ff, root_b_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic              res_red_ff, res_red_in;
   logic              res_bad_ff, res_bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_red_ff, rsp_red_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;
   logic [NODE_W-1:0] root_cur;
   logic [NODE_W-1:0] end_node;
   logic              a_ok, b_ok;
   logic              req_fire;
   logic              out_free;

   ufre_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_in),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign root_cur   = sel_ff ? root_b_ff : root_a_ff;
   assign end_node   = sel_ff ? node_b_ff : node_a_ff;
   assign a_ok       = (node_a_ff != '0) && (node_a_ff <= node_count_ff);
   assign b_ok       = (node_b_ff != '0) && (node_b_ff <= node_count_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2){1'b0}}, rsp_bad_ff, rsp_red_ff};

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      clr_idx_in   = clr_idx_ff;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      cur_in       = cur_ff;
      sel_in       = sel_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      res_red_in   = res_red_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_red_in   = rsp_red_ff;
      rsp_bad_in   = rsp_bad_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = '{rank: '0, parent: cur_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               node_a_in = req_tdata[NODE_W-1:0];
               node_b_in = req_tdata[2*NODE_W-1:NODE_W];
               if (req_tuser) begin
                  state_in   = ST_CLEAR;
                  pend_in    = 1'b1;
                  clr_idx_in = '0;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '{rank: '0, parent: clr_idx_ff};
            clr_idx_in = clr_idx_ff + NODE_W'(1);
            if (clr_idx_ff == NODE_LAST) begin
               state_in = pend_ff ? ST_START : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_START: begin
            res_red_in = 1'b0;
            res_bad_in = 1'b0;
            sel_in     = 1'b0;
            if (!a_ok || !b_ok) begin
               res_bad_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               cur_in   = node_a_ff;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (rd_data.parent == cur_ff) begin
               if (sel_ff) begin
                  root_b_in = cur_ff;
                  rank_b_in = rd_data.rank;
               end else begin
                  root_a_in = cur_ff;
                  rank_a_in = rd_data.rank;
               end
               if (end_node == cur_ff) begin
                  if (sel_ff) begin
                     state_in = ST_MERGE;
                  end else begin
                     sel_in = 1'b1;
                     cur_in = node_b_ff;
                  end
               end else begin
                  cur_in   = end_node;
                  state_in = ST_COMP;
               end
            end else begin
               cur_in = rd_data.parent;
            end
         end
         ST_COMP: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = '{rank: rd_data.rank, parent: root_cur};
            if (rd_data.parent == root_cur) begin
               if (sel_ff) begin
                  state_in = ST_MERGE;
               end else begin
                  sel_in   = 1'b1;
                  cur_in   = node_b_ff;
                  state_in = ST_FIND;
               end
            end else begin
               cur_in = rd_data.parent;
            end
         end
         ST_MERGE: begin
            state_in = ST_DONE;
            if (root_a_ff == root_b_ff) begin
               res_red_in = 1'b1;
            end else if (rank_b_ff > rank_a_ff) begin
               wr_en   = 1'b1;
               wr_addr = root_a_ff;
               wr_data = '{rank: rank_a_ff, parent: root_b_ff};
            end else begin
               wr_en   = 1'b1;
               wr_addr = root_b_ff;
               wr_data = '{rank: rank_b_ff, parent: root_a_ff};
               if (rank_a_ff == rank_b_ff) begin
                  state_in = ST_BUMP;
               end
            end
         end
         ST_BUMP: begin
            wr_en    = 1'b1;
            wr_addr  = root_a_ff;
            wr_data  = '{rank: (rank_a_ff == RANK_MAX) ? rank_a_ff
                                                        : rank_a_ff + RANK_W'(1),
                         parent: root_a_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = res_red_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pend_ff       <= 1'b0;
         clr_idx_ff    <= '0;
         node_count_ff <= COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_a_ff  <= node_a_in;
      node_b_ff  <= node_b_in;
      cur_ff     <= cur_in;
      root_a_ff  <= root_a_in;
      root_b_ff  <= root_b_in;
      rank_a_ff  <= rank_a_in;
      rank_b_ff  <= rank_b_in;
      res_red_ff <= res_red_in;
      res_bad_ff <= res_bad_in;
      rsp_red_ff <= rsp_red_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   // Node zero is never linked into a set, so a walk must never reach it.
   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIND) || (state_ff == ST_COMP)) |-> (cur_ff != '0))
      else $error("root walk reached node zero");

   // A response never reports both a redundant edge and a bad endpoint.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_red_ff && rsp_bad_ff))
      else $error("response carries both flags");

   // The table is only written while sweeping, compressing or merging.
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == ST_CLEAR) || (state_ff == ST_COMP) ||
                 (state_ff == ST_MERGE) || (state_ff == ST_BUMP)))
      else $error("table written outside an update state");

   // A merge never hangs a root under itself.
   a_merge_distinct: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_MERGE)) |-> (root_a_ff != root_b_ff))
      else $error("merge of a set with itself");

   // A finished request leaves for the idle state only by loading the output register.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("response lost on completion");

endmodule
